@@ rtl/core/sh64_pkg.sv @@
// SeaHash 64-bit stream hasher: shared types and constants.
// Used by the top level seahash_64bit_stream_hash; no dependencies.
package sh64_pkg;

	localparam logic [63:0] MIX_MUL    = 64'h6eed0e9da4d94a4f;
	localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
	localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];

	localparam int unsigned LANE_COUNT = 4;
	localparam int unsigned WORD_BYTES = 8;

	typedef logic [63:0] word_t;
	typedef logic [3:0]  byte_cnt_t;
	typedef logic [1:0]  lane_idx_t;

	// Keep bytes below the valid count, clear the rest.
	function automatic word_t byte_mask(input byte_cnt_t n);
		word_t m;
		m = '0;
		for (int i = 0; i < WORD_BYTES; i++) begin
			if (4'(i) < n)
				m[i*8 +: 8] = 8'hff;
		end
		return m;
	endfunction

endpackage

@@ rtl/core/seahash_64bit_stream_hash.sv @@
// SeaHash 64-bit stream hasher, top level.
// Input words arrive on a valid/stall channel; hash results leave on another.
// Seeds are written through a plain write port: index 0..3 selects seed_q[0..3].
// A message is a run of words closed by last_word; the first word of a message
// loads the four lanes from the seeds and clears the byte count.
// One 32x32 multiplier is shared: a 64-bit multiply forms the low product, then
// folds two cross products into the upper half; one mix is multiply, shift-xor,
// multiply.
// A word with valid bytes runs one mix; in_stall is high meanwhile, so the next
// word is accepted only once the block has returned to its idle state.
// A last word adds a final mix, after which the result is loaded into the output
// register and shown on out_valid; an empty last word runs only the final mix.
// The result sits in an output register; the next message may start while it
// waits. If out_stall holds that register full when another result is ready,
// the block waits in its output state and keeps in_stall high.
// Reset clears the seeds to zero, closes any open message and empties the
// output register.
module seahash_64bit_stream_hash
	import sh64_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_XS   = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	localparam lane_idx_t REG_SEED0 = 2'd0;
	localparam lane_idx_t REG_SEED1 = 2'd1;
	localparam lane_idx_t REG_SEED2 = 2'd2;
	localparam lane_idx_t REG_SEED3 = 2'd3;

	word_t     seed_q [LANE_COUNT];
	word_t     lanes_q [LANE_COUNT];
	word_t     total_q;
	word_t     x_q;
	word_t     acc_q;
	word_t     hash_q;
	logic [1:0] state_q;
	logic [1:0] phase_q;
	logic      second_q;
	logic      final_q;
	logic      last_q;
	logic      open_q;
	logic      out_valid_q;

	logic      in_fire;
	byte_cnt_t n_sat;
	word_t     base_lanes [LANE_COUNT];
	word_t     base_total;
	word_t     word_masked;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	word_t     prod;
	logic [31:0] acc_hi_sum;
	word_t     mul_res;
	logic [31:0] xs_shift;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign hash_value = hash_q;

	assign n_sat       = valid_bytes[3] ? 4'd8 : valid_bytes;
	assign word_masked = data_word & byte_mask(n_sat);

	always_comb begin
		for (int i = 0; i < LANE_COUNT; i++)
			base_lanes[i] = open_q ? lanes_q[i] : seed_q[i];
		base_total = open_q ? total_q : '0;
	end

	// Shared multiplier: low word by low constant, then the two cross terms.
	always_comb begin
		mul_a = (phase_q == 2'd1) ? x_q[63:32] : x_q[31:0];
		mul_b = (phase_q == 2'd2) ? MIX_MUL_HI : MIX_MUL_LO;
	end
	assign prod       = 64'(mul_a) * 64'(mul_b);
	assign acc_hi_sum = acc_q[63:32] + prod[31:0];
	assign mul_res    = {acc_hi_sum, acc_q[31:0]};
	assign xs_shift   = x_q[63:32] >> x_q[63:60];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_COUNT; i++)
				seed_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEED0: seed_q[0] <= cfg_data;
				REG_SEED1: seed_q[1] <= cfg_data;
				REG_SEED2: seed_q[2] <= cfg_data;
				REG_SEED3: seed_q[3] <= cfg_data;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 2'd0;
			second_q    <= 1'b0;
			final_q     <= 1'b0;
			last_q      <= 1'b0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, else drop the one just taken
			if (state_q == ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						open_q   <= 1'b1;
						last_q   <= last_word;
						phase_q  <= 2'd0;
						second_q <= 1'b0;
						if (n_sat != 4'd0) begin
							final_q <= 1'b0;
							state_q <= ST_MUL;
						end else if (last_word) begin
							final_q <= 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (phase_q == 2'd2) begin
						phase_q <= 2'd0;
						if (!second_q) begin
							state_q <= ST_XS;
						end else if (final_q) begin
							state_q <= ST_OUT;
						end else if (last_q) begin
							// absorbed the last word; run the finishing mix
							final_q  <= 1'b1;
							second_q <= 1'b0;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
				ST_XS: begin
					second_q <= 1'b1;
					state_q  <= ST_MUL;
				end
				ST_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						open_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					for (int i = 0; i < LANE_COUNT; i++)
						lanes_q[i] <= base_lanes[i];
					total_q <= base_total + 64'(n_sat);
					if (n_sat != 4'd0)
						x_q <= base_lanes[0] ^ word_masked;
					else
						x_q <= base_lanes[0] ^ base_lanes[1] ^ base_lanes[2]
							^ base_lanes[3] ^ base_total;
				end
			end
			ST_MUL: begin
				unique case (phase_q)
					2'd0: acc_q <= prod;
					2'd1: acc_q[63:32] <= acc_hi_sum;
					default: begin
						if (!second_q || final_q) begin
							x_q <= mul_res;
						end else begin
							// rotate lanes, mixed value enters at the back
							lanes_q[0] <= lanes_q[1];
							lanes_q[1] <= lanes_q[2];
							lanes_q[2] <= lanes_q[3];
							lanes_q[3] <= mul_res;
							x_q <= lanes_q[1] ^ lanes_q[2] ^ lanes_q[3]
								^ mul_res ^ total_q;
						end
					end
				endcase
			end
			ST_XS: x_q <= x_q ^ {32'b0, xs_shift};
			ST_OUT: begin
				if (!out_valid_q || !out_stall)
					hash_q <= x_q;
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_out_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result appeared outside the output state");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("multiplier phase out of range");

	a_xs_first_pass: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_XS |-> !second_q && $past(state_q == ST_MUL && phase_q == 2'd2))
		else $error("shift-xor step out of sequence");

	a_close_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(open_q) |-> out_valid_q && $past(state_q == ST_OUT))
		else $error("message closed without a result");
`endif

endmodule
